// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the vertex transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PVT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PVT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PVT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PVT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hdl/pvt_pkg.sv =====
// Shared types and constants of the projective vertex transform.
package pvt_pkg;

  localparam int ROW_W     = 64;
  localparam int SLOT_W    = 16;
  localparam int NUM_ROWS  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_BITS = 16;
  localparam int STATUS_W  = 2;

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [STATUS_W-1:0]  status_t;

  localparam cfg_idx_t REG_ROW0 = 2'd0;
  localparam cfg_idx_t REG_ROW1 = 2'd1;
  localparam cfg_idx_t REG_ROW2 = 2'd2;
  localparam cfg_idx_t REG_ROW3 = 2'd3;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_SAT  = 2'd1;
  localparam status_t STAT_ZERO = 2'd2;

  localparam row_t ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam row_t ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam row_t ROW2_RESET = 64'h0000_1000_0000_0000;
  localparam row_t ROW3_RESET = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic valid;
    logic zero;
  } side_t;

endpackage

// ===== hdl/pvt_matmul.sv =====
// Two-stage matrix by vertex product: multiplies, then sums and scales to Q.16.
module pvt_matmul #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  pvt_pkg::row_t                 rows [pvt_pkg::NUM_ROWS],
  output logic                          t_valid,
  output logic signed [COORD_WIDTH+5:0] t [pvt_pkg::NUM_ROWS]
);
  import pvt_pkg::*;

  localparam int PROD_W = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_W  = PROD_W + 2;
  localparam int T_W    = COORD_WIDTH + 6;
  localparam int SHIFT  = COEF_WIDTH - 4;

  logic signed [COORD_WIDTH-1:0] vec [3];
  logic signed [COEF_WIDTH-1:0]  cf [NUM_ROWS][NUM_ROWS];
  logic signed [PROD_W-1:0]      p_r [NUM_ROWS][3];
  logic signed [PROD_W-1:0]      p_nxt [NUM_ROWS][3];
  logic signed [COEF_WIDTH-1:0]  k_r [NUM_ROWS];
  logic signed [COEF_WIDTH-1:0]  k_nxt [NUM_ROWS];
  logic signed [SUM_W-1:0]       sum [NUM_ROWS];
  logic signed [T_W-1:0]         t_r [NUM_ROWS];
  logic signed [T_W-1:0]         t_nxt [NUM_ROWS];
  logic                          s1_valid_r;
  logic                          t_valid_r;

  always_comb begin
    vec[0] = in_x;
    vec[1] = in_y;
    vec[2] = in_z;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        cf[r][c] = rows[r][SLOT_W*c +: COEF_WIDTH];
      end
      for (int c = 0; c < 3; c++) begin
        p_nxt[r][c] = PROD_W'(cf[r][c]) * PROD_W'(vec[c]);
      end
      k_nxt[r] = cf[r][3];
      sum[r] = SUM_W'(p_r[r][0]) + SUM_W'(p_r[r][1]) + SUM_W'(p_r[r][2])
             + (SUM_W'(k_r[r]) <<< FRAC_BITS);
      t_nxt[r] = T_W'(sum[r] >>> SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      t_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      t_valid_r  <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    k_r <= k_nxt;
    t_r <= t_nxt;
  end

  assign t_valid = t_valid_r;
  assign t       = t_r;

endmodule

// ===== hdl/pvt_div_lane.sv =====
// Pipelined restoring divider lane producing a saturated signed Q.16 quotient.
module pvt_div_lane #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic signed [COORD_WIDTH+5:0] t_in,
  input  logic signed [COORD_WIDTH+5:0] tw_in,
  output logic signed [COORD_WIDTH-1:0] q,
  output logic                          sat
);
  import pvt_pkg::*;

  localparam int T_W    = COORD_WIDTH + 6;
  localparam int STEPS  = COORD_WIDTH;
  localparam int PRE_SH = COORD_WIDTH - FRAC_BITS;
  localparam int CMP_W  = T_W + PRE_SH;
  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic [T_W-1:0]         num_a;
  logic [T_W-1:0]         den_a;
  logic [T_W-1:0]         rem_r [STEPS+1];
  logic [T_W-1:0]         rem_nxt [STEPS+1];
  logic [T_W-1:0]         den_r [STEPS+1];
  logic [T_W-1:0]         den_nxt [STEPS+1];
  logic [COORD_WIDTH-1:0] nb_r [STEPS+1];
  logic [COORD_WIDTH-1:0] nb_nxt [STEPS+1];
  logic [COORD_WIDTH-1:0] qb_r [STEPS+1];
  logic [COORD_WIDTH-1:0] qb_nxt [STEPS+1];
  logic                   neg_r [STEPS+1];
  logic                   neg_nxt [STEPS+1];
  logic                   ovf_r [STEPS+1];
  logic                   ovf_nxt [STEPS+1];
  logic [T_W:0]           trial [STEPS];
  logic                   ge [STEPS];
  logic [COORD_WIDTH-1:0] lim;
  logic [COORD_WIDTH-1:0] qs;
  logic                   sat_f;
  logic [COORD_WIDTH-1:0] qo_r;
  logic [COORD_WIDTH-1:0] qo_nxt;
  logic                   sat_r;
  logic                   sat_nxt;

  always_comb begin
    num_a = t_in[T_W-1] ? $unsigned(-t_in) : $unsigned(t_in);
    den_a = tw_in[T_W-1] ? $unsigned(-tw_in) : $unsigned(tw_in);
    neg_nxt[0] = t_in[T_W-1] ^ tw_in[T_W-1];
    ovf_nxt[0] = CMP_W'(num_a) >= (CMP_W'(den_a) << PRE_SH);
    rem_nxt[0] = T_W'(num_a >> PRE_SH);
    den_nxt[0] = den_a;
    nb_nxt[0]  = COORD_WIDTH'({num_a, {FRAC_BITS{1'b0}}});
    qb_nxt[0]  = '0;
    for (int k = 0; k < STEPS; k++) begin
      trial[k] = {rem_r[k], nb_r[k][COORD_WIDTH-1]};
      ge[k] = trial[k] >= {1'b0, den_r[k]};
      rem_nxt[k+1] = ge[k] ? T_W'(trial[k] - {1'b0, den_r[k]}) : T_W'(trial[k]);
      den_nxt[k+1] = den_r[k];
      nb_nxt[k+1]  = nb_r[k] << 1;
      qb_nxt[k+1]  = COORD_WIDTH'({qb_r[k], ge[k]});
      neg_nxt[k+1] = neg_r[k];
      ovf_nxt[k+1] = ovf_r[k];
    end
    lim     = neg_r[STEPS] ? CMIN : CMAX;
    sat_f   = ovf_r[STEPS] || (qb_r[STEPS] > lim);
    qs      = sat_f ? lim : qb_r[STEPS];
    qo_nxt  = neg_r[STEPS] ? COORD_WIDTH'(-qs) : qs;
    sat_nxt = sat_f;
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    nb_r  <= nb_nxt;
    qb_r  <= qb_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
    qo_r  <= qo_nxt;
    sat_r <= sat_nxt;
  end

  assign q   = $signed(qo_r);
  assign sat = sat_r;

endmodule

// ===== hdl/projective_vertex_transform_core.sv =====
// Top level of the homogeneous 4x4 vertex transform with perspective divide.
//
// One vertex is taken in every clock cycle; busy never rises. Each vertex's
// result appears on the out_ ports for one cycle with out_valid high, once it
// has passed the multiply and sum registers of the matrix product, then the
// divider lanes that retire one quotient bit per pipeline stage, then the
// saturation stage and the output register.
// Results cannot be held off, so the receiver must take each one as it comes.
// Matrix rows are written through the cfg_ port, which is always ready; write
// them only while no vertex is in flight.
module projective_vertex_transform_core #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output pvt_pkg::status_t              out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  pvt_pkg::cfg_idx_t             cfg_index,
  input  pvt_pkg::row_t                 cfg_data
);
  import pvt_pkg::*;
  `include "assert_macros.svh"

  localparam int T_W     = COORD_WIDTH + 6;
  localparam int DIV_LAT = COORD_WIDTH + 2;
  localparam int TOT_LAT = COORD_WIDTH + 5;
  localparam logic [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  row_t                          rows_r [NUM_ROWS];
  row_t                          rows_nxt [NUM_ROWS];
  logic                          t_valid;
  logic signed [T_W-1:0]         t [NUM_ROWS];
  logic signed [COORD_WIDTH-1:0] q [3];
  logic                          sat [3];
  side_t                         side_r [DIV_LAT];
  side_t                         side_nxt [DIV_LAT];
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] out_c_r [3];
  logic signed [COORD_WIDTH-1:0] out_c_nxt [3];
  status_t                       status_r;
  status_t                       status_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    rows_nxt = rows_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_ROW0: rows_nxt[0] = cfg_data;
        REG_ROW1: rows_nxt[1] = cfg_data;
        REG_ROW2: rows_nxt[2] = cfg_data;
        REG_ROW3: rows_nxt[3] = cfg_data;
        default: rows_nxt = rows_r;
      endcase
    end
  end

  pvt_matmul #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_matmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy),
    .in_x    (in_x),
    .in_y    (in_y),
    .in_z    (in_z),
    .rows    (rows_r),
    .t_valid (t_valid),
    .t       (t)
  );

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pvt_div_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk  (clk),
      .t_in (t[g]),
      .tw_in(t[3]),
      .q    (q[g]),
      .sat  (sat[g])
    );
  end

  always_comb begin
    side_nxt[0].valid = t_valid;
    side_nxt[0].zero  = (t[3] == '0);
    for (int k = 1; k < DIV_LAT; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    out_valid_nxt = side_r[DIV_LAT-1].valid;
    if (side_r[DIV_LAT-1].zero) begin
      for (int i = 0; i < 3; i++) begin
        out_c_nxt[i] = '0;
      end
      status_nxt = STAT_ZERO;
    end else begin
      for (int i = 0; i < 3; i++) begin
        out_c_nxt[i] = q[i];
      end
      status_nxt = (sat[0] || sat[1] || sat[2]) ? STAT_SAT : STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0]   <= ROW0_RESET;
      rows_r[1]   <= ROW1_RESET;
      rows_r[2]   <= ROW2_RESET;
      rows_r[3]   <= ROW3_RESET;
      side_r      <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_c_r  <= out_c_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_c_r[0];
  assign out_y      = out_c_r[1];
  assign out_z      = out_c_r[2];
  assign out_status = status_r;

  `PVT_ASSERT(a_latency, clk, rst_n, out_valid |-> $past(start, TOT_LAT), "result without a transaction")
  `PVT_NEVER(a_zero_out, clk, rst_n, out_valid && (out_status == STAT_ZERO) && (out_x != '0 || out_y != '0 || out_z != '0), "zero w with nonzero coordinates")
  `PVT_ASSERT(a_sat_lim, clk, rst_n, (out_valid && out_status == STAT_SAT) |-> (out_x == CMAX || out_x == CMIN || out_y == CMAX || out_y == CMIN || out_z == CMAX || out_z == CMIN), "saturation flagged without a limit value")

endmodule
